// ===== sv/swtd_pkg.sv =====
// Shared types and constants of the software timer dispatcher.
// Holds field widths, action and status codes, controller states and the
// command and status bundles between controller and datapath. No dependencies.
package swtd_pkg;

  localparam int unsigned ACTION_W      = 2;
  localparam int unsigned PERIOD_W      = 32;
  localparam int unsigned ID_W          = 8;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned RES_W         = 8;
  localparam int unsigned PRESCALE_W    = 10;
  localparam int unsigned TICK_W        = 32;
  localparam int unsigned PRESCALE_MULT = 4;
  localparam int unsigned MAX_RESULTS   = 8;
  localparam int unsigned FIRE_CNT_W    = 4;

  localparam logic [RES_W-1:0] RES_RESET = 8'd1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRED  = 1'b1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_RD,
    S_SCAN_WAIT,
    S_SCAN_DIV,
    S_SCAN_PUSH,
    S_FLUSH,
    S_STOP_RD,
    S_STOP_CMP,
    S_STOP_MOVE,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [ID_W-1:0]     id;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    tick;
    logic    append;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_idx;
    logic    rd_last;
    logic    move;
    logic    div_start;
    logic    pend_load;
    logic    pend_clr;
    logic    set_status;
    status_e res_status;
    logic    out_status;
    logic    out_pend;
    logic    out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                wrap;
    logic                full;
    logic                idx_lt_cnt;
    logic                period_zero;
    logic                div_done;
    logic                rem_zero;
    logic                id_match;
    logic                fire_room;
    logic                pend_valid;
    logic                out_free;
  } stat_t;

endpackage

// ===== sv/swtd_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on swtd_pkg for the field widths.
interface swtd_in_if;
  logic                          valid;
  logic                          ready;
  logic [swtd_pkg::ACTION_W-1:0] action;
  logic [swtd_pkg::PERIOD_W-1:0] period;
  logic [swtd_pkg::ID_W-1:0]     consumer_id;

  modport source (output valid, action, period, consumer_id, input ready);
  modport sink   (input valid, action, period, consumer_id, output ready);
  modport mon    (input valid, ready, action, period, consumer_id);
endinterface

interface swtd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [swtd_pkg::STATUS_W-1:0] status;
  logic [swtd_pkg::ID_W-1:0]     fired_id;
  logic                          last;

  modport source (output valid, kind, status, fired_id, last, input ready);
  modport sink   (input valid, kind, status, fired_id, last, output ready);
  modport mon    (input valid, ready, kind, status, fired_id, last);
endinterface

// ===== sv/software_timer_dispatcher_unit.sv =====
// One item at a time. A start answers after decode; a stop searches the table entry by entry.
// A tick without a count wrap returns to idle after decode. A tick with a wrap scans the
// table and runs the remainder unit for each entry with a nonzero period.
// A result waits in the output register; the next result of a tick waits for it.
// Reset clears the counters, empties the table and sets resolution to 1.
// Top level of the dispatcher; depends on swtd_pkg, swtd_if, swtd_ctrl, swtd_dp.
module software_timer_dispatcher_unit #(
  parameter int unsigned NumTasks = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [swtd_pkg::RES_W-1:0] cfg_wdata_i,
  swtd_in_if.sink                    item_i,
  swtd_out_if.source                 result_o
);

  swtd_pkg::cmd_t  cmd;
  swtd_pkg::stat_t stat;

  swtd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  swtd_dp #(
    .NumTasks (NumTasks)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_action_i  (item_i.action),
    .in_period_i  (item_i.period),
    .in_id_i      (item_i.consumer_id),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (result_o.ready),
    .out_valid_o  (result_o.valid),
    .out_kind_o   (result_o.kind),
    .out_status_o (result_o.status),
    .out_id_o     (result_o.fired_id),
    .out_last_o   (result_o.last)
  );

endmodule

// ===== sv/swtd_rem.sv =====
// Iterative remainder unit: one restoring step per cycle over the dividend.
// Depends on swtd_pkg for the word width.
module swtd_rem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [swtd_pkg::TICK_W-1:0] dividend_i,
  input  logic [swtd_pkg::TICK_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [swtd_pkg::TICK_W-1:0] rem_o
);

  localparam int unsigned W     = swtd_pkg::TICK_W;
  localparam int unsigned StepW = $clog2(W);

  logic             busy_q, done_q;
  logic [StepW-1:0] step_q;
  logic [W-1:0]     num_q, rem_q, div_q;
  logic [W:0]       trial, diff;
  logic             ge;
  logic [W-1:0]     rem_d;

  always_comb begin
    trial = {rem_q, num_q[W-1]};
    diff  = trial - {1'b0, div_q};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? diff[W-1:0] : trial[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == StepW'(W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/swtd_ctrl.sv =====
// Controller state machine of the dispatcher: sequences ticks, table scans,
// starts and stops. Depends on swtd_pkg for states, commands and status.
module swtd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  swtd_pkg::stat_t stat_i,
  output swtd_pkg::cmd_t  cmd_o
);

  swtd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swtd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == swtd_pkg::S_IDLE);
    case (state_q)
      swtd_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = swtd_pkg::S_DECODE;
        end
      end
      swtd_pkg::S_DECODE: begin
        case (stat_i.action)
          swtd_pkg::ACT_TICK: begin
            cmd_o.tick = 1'b1;
            if (stat_i.wrap) begin
              cmd_o.idx_clr = 1'b1;
              state_d       = swtd_pkg::S_SCAN_RD;
            end else begin
              state_d = swtd_pkg::S_IDLE;
            end
          end
          swtd_pkg::ACT_START: begin
            cmd_o.set_status = 1'b1;
            if (stat_i.full) begin
              cmd_o.res_status = swtd_pkg::ST_FULL;
            end else begin
              cmd_o.append     = 1'b1;
              cmd_o.res_status = swtd_pkg::ST_OK;
            end
            state_d = swtd_pkg::S_RESULT;
          end
          swtd_pkg::ACT_STOP: begin
            cmd_o.idx_clr = 1'b1;
            state_d       = swtd_pkg::S_STOP_RD;
          end
          default: begin
            state_d = swtd_pkg::S_IDLE;
          end
        endcase
      end
      swtd_pkg::S_SCAN_RD: begin
        if (stat_i.idx_lt_cnt) begin
          cmd_o.rd_idx = 1'b1;
          state_d      = swtd_pkg::S_SCAN_WAIT;
        end else begin
          state_d = swtd_pkg::S_FLUSH;
        end
      end
      swtd_pkg::S_SCAN_WAIT: begin
        if (stat_i.period_zero) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = swtd_pkg::S_SCAN_RD;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = swtd_pkg::S_SCAN_DIV;
        end
      end
      swtd_pkg::S_SCAN_DIV: begin
        if (stat_i.div_done) begin
          if (stat_i.rem_zero && stat_i.fire_room) begin
            state_d = swtd_pkg::S_SCAN_PUSH;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = swtd_pkg::S_SCAN_RD;
          end
        end
      end
      // A fired consumer is held back in the pending register so that the final one of the
      // tick can be marked as last.
      swtd_pkg::S_SCAN_PUSH: begin
        if (!stat_i.pend_valid) begin
          cmd_o.pend_load = 1'b1;
          cmd_o.idx_inc   = 1'b1;
          state_d         = swtd_pkg::S_SCAN_RD;
        end else if (stat_i.out_free) begin
          cmd_o.out_pend  = 1'b1;
          cmd_o.pend_load = 1'b1;
          cmd_o.idx_inc   = 1'b1;
          state_d         = swtd_pkg::S_SCAN_RD;
        end
      end
      swtd_pkg::S_FLUSH: begin
        if (!stat_i.pend_valid) begin
          state_d = swtd_pkg::S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.out_pend = 1'b1;
          cmd_o.out_last = 1'b1;
          cmd_o.pend_clr = 1'b1;
          state_d        = swtd_pkg::S_IDLE;
        end
      end
      swtd_pkg::S_STOP_RD: begin
        if (stat_i.idx_lt_cnt) begin
          cmd_o.rd_idx = 1'b1;
          state_d      = swtd_pkg::S_STOP_CMP;
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.res_status = swtd_pkg::ST_NOT_FOUND;
          state_d          = swtd_pkg::S_RESULT;
        end
      end
      swtd_pkg::S_STOP_CMP: begin
        if (stat_i.id_match) begin
          cmd_o.rd_last = 1'b1;
          state_d       = swtd_pkg::S_STOP_MOVE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = swtd_pkg::S_STOP_RD;
        end
      end
      swtd_pkg::S_STOP_MOVE: begin
        cmd_o.move       = 1'b1;
        cmd_o.set_status = 1'b1;
        cmd_o.res_status = swtd_pkg::ST_OK;
        state_d          = swtd_pkg::S_RESULT;
      end
      swtd_pkg::S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.out_status = 1'b1;
          state_d          = swtd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = swtd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/swtd_dp.sv =====
// Datapath of the dispatcher: prescaler, tick count, consumer table memory,
// remainder unit and result register. Depends on swtd_pkg and swtd_rem.
module swtd_dp #(
  parameter int unsigned NumTasks = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swtd_pkg::RES_W-1:0]    cfg_wdata_i,
  input  logic [swtd_pkg::ACTION_W-1:0] in_action_i,
  input  logic [swtd_pkg::PERIOD_W-1:0] in_period_i,
  input  logic [swtd_pkg::ID_W-1:0]     in_id_i,
  input  swtd_pkg::cmd_t                cmd_i,
  output swtd_pkg::stat_t               stat_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          out_kind_o,
  output logic [swtd_pkg::STATUS_W-1:0] out_status_o,
  output logic [swtd_pkg::ID_W-1:0]     out_id_o,
  output logic                          out_last_o
);

  localparam int unsigned CntW = $clog2(NumTasks + 1);
  localparam int unsigned IdxW = (NumTasks > 1) ? $clog2(NumTasks) : 1;
  localparam int unsigned PW   = swtd_pkg::PRESCALE_W;

  // Configuration and counters.
  logic [swtd_pkg::RES_W-1:0]    resolution_q;
  logic [PW-1:0]                 prescale_q;
  logic [swtd_pkg::TICK_W-1:0]   tick_q;
  logic [CntW-1:0]               cnt_q, idx_q, last_idx;
  logic [swtd_pkg::FIRE_CNT_W-1:0] fire_cnt_q;

  // Captured item and pending results.
  logic [swtd_pkg::ACTION_W-1:0] action_q;
  logic [swtd_pkg::PERIOD_W-1:0] period_q;
  logic [swtd_pkg::ID_W-1:0]     id_q;
  swtd_pkg::status_e             res_status_q;
  logic                          pend_valid_q;
  logic [swtd_pkg::ID_W-1:0]     pend_id_q;
  logic                          out_valid_q;
  logic                          out_kind_q;
  logic [swtd_pkg::STATUS_W-1:0] out_status_q;
  logic [swtd_pkg::ID_W-1:0]     out_id_q;
  logic                          out_last_q;

  // Table memory.
  swtd_pkg::entry_t tbl_q [NumTasks];
  swtd_pkg::entry_t rd_entry_q;
  swtd_pkg::entry_t wr_entry;
  logic             tbl_we, tbl_re;
  logic [IdxW-1:0]  wr_addr, rd_addr;

  logic [swtd_pkg::RES_W-1:0]  res_eff;
  logic [PW-1:0]               limit;
  logic [PW:0]                 pre_next;
  logic                        wrap;
  logic                        div_done;
  logic [swtd_pkg::TICK_W-1:0] rem;
  logic                        out_load;

  // A resolution of zero behaves as one.
  always_comb begin
    res_eff  = (resolution_q == '0) ? swtd_pkg::RES_W'(1) : resolution_q;
    limit    = PW'(res_eff) * PW'(swtd_pkg::PRESCALE_MULT);
    pre_next = {1'b0, prescale_q} + (PW + 1)'(1);
    wrap     = pre_next >= {1'b0, limit};
    last_idx = cnt_q - 1'b1;
  end

  always_comb begin
    tbl_we   = cmd_i.append | cmd_i.move;
    wr_addr  = cmd_i.append ? cnt_q[IdxW-1:0] : idx_q[IdxW-1:0];
    wr_entry = cmd_i.append ? {period_q, id_q} : rd_entry_q;
    tbl_re   = cmd_i.rd_idx | cmd_i.rd_last;
    rd_addr  = cmd_i.rd_last ? last_idx[IdxW-1:0] : idx_q[IdxW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_q[wr_addr] <= wr_entry;
    end
    if (tbl_re) begin
      rd_entry_q <= tbl_q[rd_addr];
    end
  end

  swtd_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (tick_q),
    .divisor_i  (rd_entry_q.period),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  assign out_load = cmd_i.out_status | cmd_i.out_pend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resolution_q <= swtd_pkg::RES_RESET;
      prescale_q   <= '0;
      tick_q       <= '0;
      cnt_q        <= '0;
      idx_q        <= '0;
      fire_cnt_q   <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        resolution_q <= cfg_wdata_i;
      end
      if (cmd_i.tick) begin
        if (wrap) begin
          prescale_q <= '0;
          tick_q     <= tick_q + 1'b1;
        end else begin
          prescale_q <= pre_next[PW-1:0];
        end
      end
      if (cmd_i.append) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.move) begin
        cnt_q <= last_idx;
      end
      if (cmd_i.idx_clr) begin
        idx_q      <= '0;
        fire_cnt_q <= '0;
      end else begin
        if (cmd_i.idx_inc) begin
          idx_q <= idx_q + 1'b1;
        end
        if (cmd_i.pend_load) begin
          fire_cnt_q <= fire_cnt_q + 1'b1;
        end
      end
      if (cmd_i.pend_load) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.pend_clr) begin
        pend_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= in_action_i;
      period_q <= in_period_i;
      id_q     <= in_id_i;
    end
    if (cmd_i.set_status) begin
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.pend_load) begin
      pend_id_q <= rd_entry_q.id;
    end
    if (cmd_i.out_status) begin
      out_kind_q   <= swtd_pkg::KIND_STATUS;
      out_status_q <= res_status_q;
      out_id_q     <= id_q;
      out_last_q   <= 1'b1;
    end else if (cmd_i.out_pend) begin
      out_kind_q   <= swtd_pkg::KIND_FIRED;
      out_status_q <= swtd_pkg::ST_OK;
      out_id_q     <= pend_id_q;
      out_last_q   <= cmd_i.out_last;
    end
  end

  always_comb begin
    stat_o.action      = action_q;
    stat_o.wrap        = wrap;
    stat_o.full        = (cnt_q == CntW'(NumTasks));
    stat_o.idx_lt_cnt  = (idx_q < cnt_q);
    stat_o.period_zero = (rd_entry_q.period == '0);
    stat_o.div_done    = div_done;
    stat_o.rem_zero    = (rem == '0);
    stat_o.id_match    = (rd_entry_q.id == id_q);
    stat_o.fire_room   = (fire_cnt_q < swtd_pkg::FIRE_CNT_W'(swtd_pkg::MAX_RESULTS));
    stat_o.pend_valid  = pend_valid_q;
    stat_o.out_free    = !out_valid_q;
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_status_o = out_status_q;
  assign out_id_o     = out_id_q;
  assign out_last_o   = out_last_q;

endmodule

// ===== sv/swtd_chk.sv =====
// Port-level checks of the dispatcher, bound to the top level.
// Depends on swtd_pkg and swtd_if.
module swtd_chk (
  input logic        clk_i,
  input logic        rst_ni,
  swtd_in_if.sink    item_i,
  swtd_out_if.source result_i
);

  // A result transaction that is not taken stays put.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_i.valid && !result_i.ready |=>
      result_i.valid && $stable(result_i.fired_id) && $stable(result_i.kind) &&
      $stable(result_i.status) && $stable(result_i.last))
    else $error("result changed while stalled");

  // Fired results always carry an ok status.
  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_i.valid && (result_i.kind == swtd_pkg::KIND_FIRED) |->
      (result_i.status == swtd_pkg::ST_OK))
    else $error("fired result with nonzero status");

  // A start or stop produces exactly one result, so it is always the last one.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_i.valid && (result_i.kind == swtd_pkg::KIND_STATUS) |-> result_i.last)
    else $error("status result without last");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready |=> !item_i.ready)
    else $error("item accepted while busy");

endmodule

bind software_timer_dispatcher_unit swtd_chk u_swtd_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .item_i   (item_i),
  .result_i (result_o)
);
